>>> hw/rtl/m3p_pkg.sv
// ----------------------------------------------------------------------------
// m3p_pkg
// Shared constants for the median-of-three three-way partition core.
// ----------------------------------------------------------------------------
package m3p_pkg;

    // Element storage
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 64;

    // Result word layout
    localparam int POS_W      = 10;
    localparam int TOTAL_W    = 11;
    localparam int RES_BITS   = VALUE_W + POS_W + 2 * TOTAL_W + 1;
    localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Command selector on the input side
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_ELEMENT = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [ADDR_W-1:0]  t_addr;

endpackage

>>> hw/rtl/m3p_ram.sv
// ----------------------------------------------------------------------------
// m3p_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module m3p_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/median3_three_way_partition_core.sv
// ----------------------------------------------------------------------------
// median3_three_way_partition_core
// Loads signed 64-bit elements, picks a median-of-three pivot and writes a
// stable three-way partition that is then read back one word at a time.
// ----------------------------------------------------------------------------
// A load word without last is stored as it is accepted; a load word with last
// also picks a median-of-three pivot and makes two read passes over the input
// store through one shared comparator, plus any wait for the result register;
// a read word is answered once the result register is free.
// Throughput: one word at a time; the input is not ready while a word is
// being worked on. Synchronous active-low reset clears all control state.
// ----------------------------------------------------------------------------
module median3_three_way_partition_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Load/read words
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [m3p_pkg::VALUE_W-1:0]      i_s_tdata,  // value
    input  logic                             i_s_tuser,  // cmd
    input  logic                             i_s_tlast,  // last
    // Result words
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // value_res, position, less_count, equal_count, overflow, zero padding
    output logic [m3p_pkg::RES_DATA_W-1:0]   o_m_tdata,
    output logic [1:0]                       o_m_tuser,  // kind
    output logic                             o_m_tlast   // final_res
);

    import m3p_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDA    = 4'd1;
    localparam logic [3:0] S_RDB    = 4'd2;
    localparam logic [3:0] S_RDC    = 4'd3;
    localparam logic [3:0] S_CAPC   = 4'd4;
    localparam logic [3:0] S_CMPBC  = 4'd5;
    localparam logic [3:0] S_CMPAC  = 4'd6;
    localparam logic [3:0] S_COUNT  = 4'd7;
    localparam logic [3:0] S_SCINIT = 4'd8;
    localparam logic [3:0] S_SCAT   = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_REMIT  = 4'd11;
    localparam logic [3:0] S_NONE   = 4'd12;

    // Control registers
    logic [3:0] r_state, n_state;
    t_count     r_count, n_count;
    t_count     r_rd_index, n_rd_index;
    logic       r_ready, n_ready;
    logic       r_ovf, n_ovf;
    t_count     r_idx, n_idx;
    logic       r_dv, n_dv;
    t_count     r_less, n_less;
    t_count     r_equal, n_equal;
    t_value     r_pivot, n_pivot;
    logic       r_out_valid, n_out_valid;

    // Datapath registers
    t_value     r_a, n_a;
    t_value     r_b, n_b;
    t_value     r_c, n_c;
    logic       r_lt_ab, n_lt_ab;
    logic       r_le_ab, n_le_ab;
    logic       r_lt_bc, n_lt_bc;
    logic       r_le_bc, n_le_bc;
    t_count     r_lt_ptr, n_lt_ptr;
    t_count     r_eq_ptr, n_eq_ptr;
    t_count     r_gt_ptr, n_gt_ptr;
    logic [1:0]         r_out_kind, n_out_kind;
    t_value             r_out_value, n_out_value;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic [TOTAL_W-1:0] r_out_less, n_out_less;
    logic [TOTAL_W-1:0] r_out_equal, n_out_equal;
    logic               r_out_final, n_out_final;
    logic               r_out_ovf, n_out_ovf;

    // Memory ports
    logic   in_we, in_re, out_we, out_re;
    t_addr  in_waddr, in_raddr, out_waddr, out_raddr;
    t_value in_rdata, out_rdata;

    // Shared comparator
    t_value cmp_x, cmp_y;
    logic   cmp_lt, cmp_eq;

    logic   in_accept, slot_free;
    t_count cnt_base;
    t_value median;

    m3p_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (in_re),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    m3p_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (in_rdata),
        .i_re    (out_re),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    // Operand selection for the comparator
    always_comb begin
        case (r_state)
            S_CAPC: begin
                cmp_x = r_a;
                cmp_y = r_b;
            end
            S_CMPBC: begin
                cmp_x = r_b;
                cmp_y = r_c;
            end
            S_CMPAC: begin
                cmp_x = r_a;
                cmp_y = r_c;
            end
            default: begin
                cmp_x = in_rdata;
                cmp_y = r_pivot;
            end
        endcase
    end

    assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);
    assign cmp_eq = (cmp_x == cmp_y);

    // Median of three, finished in the cycle that compares the first and last
    always_comb begin
        if ((r_le_ab && r_le_bc) || (!r_lt_bc && !r_lt_ab)) begin
            median = r_b;
        end else if ((!r_lt_ab && (cmp_lt || cmp_eq)) || (!cmp_lt && r_le_ab)) begin
            median = r_a;
        end else begin
            median = r_c;
        end
    end

    // A new load after a finished one starts again from an empty store
    assign cnt_base = r_ready ? '0 : r_count;

    // Sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_index  = r_rd_index;
        n_ready     = r_ready;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        n_less      = r_less;
        n_equal     = r_equal;
        n_pivot     = r_pivot;
        n_out_valid = r_out_valid && !i_m_tready;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_lt_ab     = r_lt_ab;
        n_le_ab     = r_le_ab;
        n_lt_bc     = r_lt_bc;
        n_le_bc     = r_le_bc;
        n_lt_ptr    = r_lt_ptr;
        n_eq_ptr    = r_eq_ptr;
        n_gt_ptr    = r_gt_ptr;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_out_less  = r_out_less;
        n_out_equal = r_out_equal;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;

        in_we     = 1'b0;
        in_waddr  = cnt_base[ADDR_W-1:0];
        in_re     = 1'b0;
        in_raddr  = r_idx[ADDR_W-1:0];
        out_we    = 1'b0;
        out_waddr = r_gt_ptr[ADDR_W-1:0];
        out_re    = 1'b0;
        out_raddr = r_rd_index[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_s_tuser == CMD_LOAD) begin
                        // Append the element, or drop it when the store is full
                        if (r_ready) begin
                            n_rd_index = '0;
                            n_ovf      = 1'b0;
                            n_ready    = 1'b0;
                        end
                        if (cnt_base < t_count'(DEPTH)) begin
                            in_we   = 1'b1;
                            n_count = cnt_base + 1'b1;
                        end else begin
                            n_count = cnt_base;
                            n_ovf   = 1'b1;
                        end
                        if (i_s_tlast) begin
                            n_state = S_RDA;
                        end
                    end else if (r_ready && (r_rd_index < r_count)) begin
                        out_re  = 1'b1;
                        n_state = S_REMIT;
                    end else begin
                        n_state = S_NONE;
                    end
                end
            end
            // Fetch first, middle and last elements
            S_RDA: begin
                in_re    = 1'b1;
                in_raddr = '0;
                n_state  = S_RDB;
            end
            S_RDB: begin
                in_re    = 1'b1;
                in_raddr = ADDR_W'(r_count >> 1);
                n_a      = in_rdata;
                n_state  = S_RDC;
            end
            S_RDC: begin
                in_re    = 1'b1;
                in_raddr = ADDR_W'(r_count - 1'b1);
                n_b      = in_rdata;
                n_state  = S_CAPC;
            end
            S_CAPC: begin
                n_c     = in_rdata;
                n_lt_ab = cmp_lt;
                n_le_ab = cmp_lt || cmp_eq;
                n_state = S_CMPBC;
            end
            S_CMPBC: begin
                n_lt_bc = cmp_lt;
                n_le_bc = cmp_lt || cmp_eq;
                n_state = S_CMPAC;
            end
            S_CMPAC: begin
                n_pivot = median;
                n_idx   = '0;
                n_less  = '0;
                n_equal = '0;
                n_state = S_COUNT;
            end
            // First pass: count elements below and equal to the pivot
            S_COUNT: begin
                if (r_idx < r_count) begin
                    in_re = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_dv  = 1'b1;
                end
                if (r_dv) begin
                    if (cmp_lt) begin
                        n_less = r_less + 1'b1;
                    end else if (cmp_eq) begin
                        n_equal = r_equal + 1'b1;
                    end
                end else if (r_idx == r_count) begin
                    n_state = S_SCINIT;
                end
            end
            S_SCINIT: begin
                n_idx    = '0;
                n_lt_ptr = '0;
                n_eq_ptr = r_less;
                n_gt_ptr = r_less + r_equal;
                n_state  = S_SCAT;
            end
            // Second pass: scatter each element to its group in input order
            S_SCAT: begin
                if (r_idx < r_count) begin
                    in_re = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_dv  = 1'b1;
                end
                if (r_dv) begin
                    out_we = 1'b1;
                    if (cmp_lt) begin
                        out_waddr = r_lt_ptr[ADDR_W-1:0];
                        n_lt_ptr  = r_lt_ptr + 1'b1;
                    end else if (cmp_eq) begin
                        out_waddr = r_eq_ptr[ADDR_W-1:0];
                        n_eq_ptr  = r_eq_ptr + 1'b1;
                    end else begin
                        n_gt_ptr = r_gt_ptr + 1'b1;
                    end
                end else if (r_idx == r_count) begin
                    n_state = S_SUM;
                end
            end
            // Summary word once the output register is free
            S_SUM: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SUMMARY;
                    n_out_value = r_pivot;
                    n_out_pos   = '0;
                    n_out_less  = TOTAL_W'(r_less);
                    n_out_equal = TOTAL_W'(r_equal);
                    n_out_final = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_ready     = 1'b1;
                    n_rd_index  = '0;
                    n_state     = S_IDLE;
                end
            end
            // Element word from the output store
            S_REMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ELEMENT;
                    n_out_value = out_rdata;
                    n_out_pos   = POS_W'(r_rd_index);
                    n_out_less  = TOTAL_W'(r_less);
                    n_out_equal = TOTAL_W'(r_equal);
                    n_out_final = (t_count'(r_rd_index + 1'b1) == r_count);
                    n_out_ovf   = r_ovf;
                    n_rd_index  = r_rd_index + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // Nothing left to read
            S_NONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_NONE;
                    n_out_value = '0;
                    n_out_pos   = '0;
                    n_out_less  = '0;
                    n_out_equal = '0;
                    n_out_final = 1'b0;
                    n_out_ovf   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_index  <= '0;
            r_ready     <= 1'b0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_less      <= '0;
            r_equal     <= '0;
            r_pivot     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_index  <= n_rd_index;
            r_ready     <= n_ready;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_less      <= n_less;
            r_equal     <= n_equal;
            r_pivot     <= n_pivot;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_c         <= n_c;
        r_lt_ab     <= n_lt_ab;
        r_le_ab     <= n_le_ab;
        r_lt_bc     <= n_lt_bc;
        r_le_bc     <= n_le_bc;
        r_lt_ptr    <= n_lt_ptr;
        r_eq_ptr    <= n_eq_ptr;
        r_gt_ptr    <= n_gt_ptr;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_out_less  <= n_out_less;
        r_out_equal <= n_out_equal;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

    // Result word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(RES_DATA_W - RES_BITS){1'b0}}, r_out_ovf, r_out_equal,
                         r_out_less, r_out_pos, r_out_value};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_final;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the median-of-three three-way partition core. Load
// and read words go in over the input stream with random gaps. A scoreboard
// keeps its own element stores, pivot and totals, and compares every result
// word field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

    import m3p_pkg::*;

    // Cycles without any accepted word before the run is abandoned.
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned TOTAL_WORDS  = 850;
    localparam int unsigned TAIL_CYCLES  = 16;

    // One expected result word, split into its fields
    typedef struct {
        logic [1:0]         kind;
        t_value             value;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] n_less;
        logic [TOTAL_W-1:0] n_equal;
        logic               final_flag;
        logic               ovf;
    } t_result;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the stores and totals, plus the queue of
    // result words still to come.
    // ------------------------------------------------------------------------
    class partition_scoreboard;
        t_value           in_store [DEPTH];
        t_value           out_store[DEPTH];
        int unsigned      elem_count;
        int unsigned      read_idx;
        bit               parted;
        bit               ovf;
        t_value           pivot;
        int unsigned      n_less;
        int unsigned      n_equal;
        t_result          pending_results[$];
        int unsigned      errors;

        function new();
            elem_count = 0;
            read_idx   = 0;
            parted     = 0;
            ovf        = 0;
            pivot      = '0;
            n_less     = 0;
            n_equal    = 0;
            errors     = 0;
        endfunction

        // Work out what an accepted input word produces.
        function void note_word(logic cmd, t_value value, logic last);
            t_result     res;
            t_value      a, b, c, v;
            int unsigned lt, eq, gt;

            res = '{kind: KIND_NONE, value: '0, position: '0, n_less: '0,
                    n_equal: '0, final_flag: 1'b0, ovf: 1'b0};

            if (cmd == CMD_LOAD) begin
                // A load after a finished partition starts a fresh set.
                if (parted) begin
                    elem_count = 0;
                    read_idx   = 0;
                    ovf        = 0;
                    parted     = 0;
                end
                if (elem_count < DEPTH) begin
                    in_store[elem_count] = value;
                    elem_count++;
                end else begin
                    ovf = 1;
                end
                if (!last)
                    return;

                // Median of first, middle and last stored elements
                a = in_store[0];
                b = in_store[elem_count / 2];
                c = in_store[elem_count - 1];
                if (($signed(a) <= $signed(b) && $signed(b) <= $signed(c)) ||
                    ($signed(c) <= $signed(b) && $signed(b) <= $signed(a)))
                    pivot = b;
                else if (($signed(b) <= $signed(a) && $signed(a) <= $signed(c)) ||
                         ($signed(c) <= $signed(a) && $signed(a) <= $signed(b)))
                    pivot = a;
                else
                    pivot = c;

                // Count, then scatter stably into the three groups
                n_less  = 0;
                n_equal = 0;
                for (int unsigned i = 0; i < elem_count; i++) begin
                    if ($signed(in_store[i]) < $signed(pivot))
                        n_less++;
                    else if (in_store[i] == pivot)
                        n_equal++;
                end
                lt = 0;
                eq = n_less;
                gt = n_less + n_equal;
                for (int unsigned i = 0; i < elem_count; i++) begin
                    v = in_store[i];
                    if ($signed(v) < $signed(pivot)) begin
                        out_store[lt] = v;
                        lt++;
                    end else if (v == pivot) begin
                        out_store[eq] = v;
                        eq++;
                    end else begin
                        out_store[gt] = v;
                        gt++;
                    end
                end
                parted   = 1;
                read_idx = 0;

                res.kind    = KIND_SUMMARY;
                res.value   = pivot;
                res.n_less  = n_less[TOTAL_W-1:0];
                res.n_equal = n_equal[TOTAL_W-1:0];
                res.ovf     = ovf;
            end else if (parted && read_idx < elem_count) begin
                res.kind       = KIND_ELEMENT;
                res.value      = out_store[read_idx];
                res.position   = read_idx[POS_W-1:0];
                res.n_less     = n_less[TOTAL_W-1:0];
                res.n_equal    = n_equal[TOTAL_W-1:0];
                res.final_flag = (read_idx + 1 == elem_count);
                res.ovf        = ovf;
                read_idx++;
            end
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_word(logic [1:0] kind, logic [RES_DATA_W-1:0] data,
                                 logic final_flag);
            t_result exp_res;
            t_result got;

            got.kind       = kind;
            got.value      = data[VALUE_W-1:0];
            got.position   = data[VALUE_W +: POS_W];
            got.n_less     = data[VALUE_W + POS_W +: TOTAL_W];
            got.n_equal    = data[VALUE_W + POS_W + TOTAL_W +: TOTAL_W];
            got.ovf        = data[VALUE_W + POS_W + 2 * TOTAL_W];
            got.final_flag = final_flag;

            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, kind %0d value %h",
                         $time, got.kind, got.value);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();

            if (got.kind !== exp_res.kind) begin
                $display("%0t: kind mismatch, expected %0d, actual %0d",
                         $time, exp_res.kind, got.kind);
                errors++;
            end
            if (got.value !== exp_res.value) begin
                $display("%0t: value mismatch, expected %h, actual %h",
                         $time, exp_res.value, got.value);
                errors++;
            end
            if (got.position !== exp_res.position) begin
                $display("%0t: position mismatch, expected %0d, actual %0d",
                         $time, exp_res.position, got.position);
                errors++;
            end
            if (got.n_less !== exp_res.n_less) begin
                $display("%0t: less count mismatch, expected %0d, actual %0d",
                         $time, exp_res.n_less, got.n_less);
                errors++;
            end
            if (got.n_equal !== exp_res.n_equal) begin
                $display("%0t: equal count mismatch, expected %0d, actual %0d",
                         $time, exp_res.n_equal, got.n_equal);
                errors++;
            end
            if (got.final_flag !== exp_res.final_flag) begin
                $display("%0t: final flag mismatch, expected %0b, actual %0b",
                         $time, exp_res.final_flag, got.final_flag);
                errors++;
            end
            if (got.ovf !== exp_res.ovf) begin
                $display("%0t: overflow flag mismatch, expected %0b, actual %0b",
                         $time, exp_res.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    t_value                s_tdata  = '0;
    logic                  s_tuser  = CMD_LOAD;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RES_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    partition_scoreboard   sb = new();
    bit                    no_idle     = 0;
    int unsigned           words_sent  = 0;
    int unsigned           results_got = 0;
    t_value                value_pool[4];

    median3_three_way_partition_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // value
        .i_s_tuser  (s_tuser),   // cmd
        .i_s_tlast  (s_tlast),   // last
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // value_res, position, less, equal, overflow
        .o_m_tuser  (m_tuser),   // kind
        .o_m_tlast  (m_tlast)    // final_res
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_value rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // Input side: wait a random gap, offer the word and hold it until taken.
    // The valid stays high between back-to-back words.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic cmd, input t_value value, input logic last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_word(cmd, value, last);
        words_sent++;
    endtask

    // Reads carry random value and last bits, which the block ignores.
    task automatic read_run(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_word(CMD_READ, rand64(), 1'($urandom_range(0, 1)));
    endtask

    // One load of n elements; duplicate-heavy sets draw from a small pool,
    // noisy ones have reads mixed into the load.
    task automatic load_frame(input int unsigned n, input bit dup_heavy,
                              input bit noisy);
        t_value v;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
                0:       value_pool[k] = {1'b1, {(VALUE_W-1){1'b0}}};
                1:       value_pool[k] = {1'b0, {(VALUE_W-1){1'b1}}};
                2:       value_pool[k] = VALUE_W'($signed($urandom_range(0, 6)) - 3);
                default: value_pool[k] = rand64();
            endcase
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                read_run(1);
            v = dup_heavy ? value_pool[$urandom_range(0, 3)] : rand64();
            send_word(CMD_LOAD, v, i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls between words, and every so often a long
    // hold-off so that the block backs up and stops taking input.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned wait_left;
        wait_left = $urandom_range(0, 15);
        forever begin
            @(posedge i_clk);
            if (m_tready && m_tvalid) begin
                sb.check_word(m_tuser, m_tdata, m_tlast);
                results_got++;
                if (results_got % 1000 == 150)
                    wait_left = 400;
                else
                    wait_left = no_idle ? 0 : $urandom_range(0, 15);
                if (wait_left > 0)
                    m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (wait_left == 0)
                    m_tready <= 1'b1;
                else
                    wait_left--;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, quiet);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        int unsigned pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Read before anything has been loaded: no data.
        read_run(1);
        // Single element at the top of the range, read it and one past the end.
        send_word(CMD_LOAD, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
        read_run(2);
        // Both extremes and zero; pivot is the middle one.
        send_word(CMD_LOAD, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
        send_word(CMD_LOAD, '0, 1'b0);
        send_word(CMD_LOAD, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
        read_run(2);
        // Duplicates of the pivot; new load starts while results are unread.
        send_word(CMD_LOAD, 64'd7, 1'b0);
        send_word(CMD_LOAD, -64'sd3, 1'b0);
        send_word(CMD_LOAD, 64'd7, 1'b0);
        send_word(CMD_LOAD, 64'd7, 1'b0);
        send_word(CMD_LOAD, -64'sd3, 1'b1);
        read_run(1);
        send_word(CMD_LOAD, {VALUE_W{1'b1}}, 1'b0);
        send_word(CMD_LOAD, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
        send_word(CMD_LOAD, {VALUE_W{1'b1}}, 1'b0);
        send_word(CMD_LOAD, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
        read_run(5);

        // Random part up to the word budget: mostly complete loads with
        // random content and reads, some with reads mixed in, some bare reads.
        while (words_sent < TOTAL_WORDS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                read_run($urandom_range(1, 4));
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
                                                : $urandom_range(1, 24);
                load_frame(n, 1'($urandom_range(0, 1)), pick == 1);
                read_run($urandom_range(0, n + 2));
            end
        end
        no_idle = 0;
        s_tvalid <= 1'b0;

        // Drain, then wait TAIL_CYCLES for anything stray.
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (sb.pending_results.size() != 0)
                $display("%0t: %0d result words never arrived", $time,
                         sb.pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
